FILE: hw/rtl/pmt_pkg.sv
package pmt_pkg;

  typedef enum logic [1:0] {
    OP_RESOLVE = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD      = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_NEXT,
    S_FINISH,
    S_OUT
  } state_e;

  localparam int unsigned PathBytes = 32;
  localparam int unsigned HardLimit = 31;
  localparam logic [7:0]  SepByte   = 8'h2F;

  // Per-entry compare status shared between scanner and top level.
  typedef struct packed {
    logic eq_all;   // all compared bytes of the entry matched so far
    logic sep_ok;   // path byte at entry length is a separator
  } cmp_t;

endpackage

FILE: hw/rtl/pmt_byte_cmp.sv
// Byte-serial comparator: one path byte against one entry byte per cycle while step_i is high.
module pmt_byte_cmp
  import pmt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       step_i,
  input  logic [4:0] idx_i,
  input  logic [4:0] elen_i,
  input  logic [7:0] path_byte_i,
  input  logic [7:0] entry_byte_i,
  output cmp_t       cmp_o
);

  logic eq_q, eq_d;
  logic sep_q, sep_d;

  always_comb begin
    eq_d  = eq_q;
    sep_d = sep_q;
    if (start_i) begin
      eq_d  = 1'b1;
      sep_d = 1'b0;
    end else if (step_i) begin
      if (idx_i < elen_i && path_byte_i != entry_byte_i) begin
        eq_d = 1'b0;
      end
      if (idx_i == elen_i) begin
        sep_d = (path_byte_i == SepByte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_q  <= 1'b0;
      sep_q <= 1'b0;
    end else begin
      eq_q  <= eq_d;
      sep_q <= sep_d;
    end
  end

  assign cmp_o = '{eq_all: eq_q, sep_ok: sep_q};

endmodule

FILE: hw/rtl/path_prefix_mount_table.sv
// Mount table with longest-prefix path resolution. Every slot is visited
// in turn: a load step, then its stored path is compared to the request
// path one byte per cycle through a shift register, and S_NEXT then
// folds the verdict. A finish step then decides and updates the table.
// Insert, remove and resolve take the same time. Only one request is in
// flight, and in_stall_o stays high until the result word has been taken,
// so the next word is accepted only once the table is idle again. The
// result sits in an output register. Status codes: ok, bad path or
// handle, duplicate, table full, not found. Slots are empty after reset;
// no clearing pass is needed.
module path_prefix_mount_table
  import pmt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES  = 16,
  parameter int unsigned MAX_PATH_BYTES = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] path_word0_i,
  input  logic [63:0] path_word1_i,
  input  logic [63:0] path_word2_i,
  input  logic [63:0] path_word3_i,
  input  logic [15:0] path_length_i,
  input  logic        entry_kind_i,
  input  logic [63:0] owner_handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        found_kind_o,
  output logic [63:0] found_owner_o,
  output logic [5:0]  remainder_offset_o
);

  localparam int unsigned SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned EffLimit = (MAX_PATH_BYTES < HardLimit) ? MAX_PATH_BYTES
                                                                 : HardLimit;

  // Entry storage: memories, one row per slot.
  logic [255:0] mem_path  [TABLE_ENTRIES];
  logic [4:0]   mem_len   [TABLE_ENTRIES];
  logic         mem_kind  [TABLE_ENTRIES];
  logic [63:0]  mem_owner [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;

  state_e state_q, state_d;

  // Request registers.
  op_e          op_q;
  logic [255:0] path_q;
  logic [15:0]  plen_q;
  logic         kind_q;
  logic [63:0]  owner_q;

  // Scan state.
  logic [SW-1:0] slot_q;
  logic [5:0]    bidx_q;
  logic [255:0]  psh_q, esh_q;      // byte shift registers
  logic [4:0]    elen_q;
  logic          evalid_q;

  // Accumulated verdicts.
  logic          best_hit_q, dup_hit_q, free_hit_q;
  logic [SW-1:0] best_slot_q, dup_slot_q, free_slot_q;
  logic [4:0]    best_len_q;
  logic [5:0]    best_off_q;

  // Result register.
  logic [2:0]  st_q;
  logic        fk_q;
  logic [63:0] fo_q;
  logic [5:0]  ro_q;

  cmp_t cmp;
  logic last_slot;
  logic in_acc, out_acc;
  logic cmp_start, cmp_step;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_o && !out_stall_i;
  assign last_slot = (slot_q == SW'(TABLE_ENTRIES - 1));

  pmt_byte_cmp u_cmp (
    .clk_i,
    .rst_ni,
    .start_i     (cmp_start),
    .step_i      (cmp_step),
    .idx_i       (bidx_q[4:0]),
    .elen_i      (elen_q),
    .path_byte_i (psh_q[7:0]),
    .entry_byte_i(esh_q[7:0]),
    .cmp_o       (cmp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = S_LOAD;
      S_LOAD:   state_d = S_SCAN;
      S_SCAN:   if (bidx_q == 6'd31) state_d = S_NEXT;
      S_NEXT:   state_d = last_slot ? S_FINISH : S_LOAD;
      S_FINISH: state_d = S_OUT;
      S_OUT:    if (out_acc) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
    cmp_start   = (state_q == S_LOAD);
    cmp_step    = (state_q == S_SCAN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= op_e'(opcode_i);
      path_q  <= {path_word3_i, path_word2_i, path_word1_i, path_word0_i};
      plen_q  <= path_length_i;
      kind_q  <= entry_kind_i;
      owner_q <= owner_handle_i;
    end
  end

  // Scan datapath: load one slot, shift a byte per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      psh_q    <= path_q;
      esh_q    <= mem_path[slot_q];
      elen_q   <= mem_len[slot_q];
      evalid_q <= valid_q[slot_q];
      bidx_q   <= '0;
    end else if (state_q == S_SCAN) begin
      psh_q  <= {8'h00, psh_q[255:8]};
      esh_q  <= {8'h00, esh_q[255:8]};
      bidx_q <= bidx_q + 6'd1;
    end
  end

  logic exact_eq, pfx_ok;
  logic [5:0] off_now;
  always_comb begin
    exact_eq = evalid_q && cmp.eq_all && (plen_q == {11'd0, elen_q});
    pfx_ok   = evalid_q && cmp.eq_all && (plen_q > {11'd0, elen_q}) && cmp.sep_ok;
    off_now  = exact_eq ? plen_q[5:0] : ({1'b0, elen_q} + 6'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      best_hit_q <= 1'b0;
      dup_hit_q  <= 1'b0;
      free_hit_q <= 1'b0;
    end else if (in_acc) begin
      slot_q     <= '0;
      best_hit_q <= 1'b0;
      dup_hit_q  <= 1'b0;
      free_hit_q <= 1'b0;
    end else if (state_q == S_NEXT) begin
      if (!last_slot) slot_q <= slot_q + SW'(1);
      if ((exact_eq || pfx_ok) && (!best_hit_q || elen_q > best_len_q)) begin
        best_hit_q  <= 1'b1;
        best_slot_q <= slot_q;
        best_len_q  <= elen_q;
        best_off_q  <= off_now;
      end
      if (exact_eq && !dup_hit_q) begin
        dup_hit_q  <= 1'b1;
        dup_slot_q <= slot_q;
      end
      if (!evalid_q && !free_hit_q) begin
        free_hit_q  <= 1'b1;
        free_slot_q <= slot_q;
      end
    end
  end

  // Final decision and table update.
  status_e st_now;
  logic do_ins, do_rem;
  always_comb begin
    do_ins = 1'b0;
    do_rem = 1'b0;
    st_now = ST_BAD;
    if (plen_q == 16'd0 || op_q == OP_UNUSED) begin
      st_now = ST_BAD;
    end else begin
      unique case (op_q)
        OP_RESOLVE: st_now = best_hit_q ? ST_OK : ST_NOTFOUND;
        OP_INSERT: begin
          if (plen_q > 16'(EffLimit) || (kind_q && owner_q == 64'd0)) st_now = ST_BAD;
          else if (dup_hit_q)  st_now = ST_DUP;
          else if (!free_hit_q) st_now = ST_FULL;
          else begin
            st_now = ST_OK;
            do_ins = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (dup_hit_q) begin
            st_now = ST_OK;
            do_rem = 1'b1;
          end else begin
            st_now = ST_NOTFOUND;
          end
        end
        default: st_now = ST_BAD;
      endcase
    end
  end

  logic [255:0] ins_mask;
  always_comb begin
    for (int i = 0; i < PathBytes; i++) begin
      ins_mask[8*i +: 8] = (16'(i) < plen_q) ? 8'hFF : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FINISH && do_ins) begin
      mem_path[free_slot_q]  <= path_q & ins_mask;
      mem_len[free_slot_q]   <= plen_q[4:0];
      mem_kind[free_slot_q]  <= kind_q;
      mem_owner[free_slot_q] <= owner_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (state_q == S_FINISH) begin
      if (do_ins) valid_q[free_slot_q] <= 1'b1;
      if (do_rem) valid_q[dup_slot_q]  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FINISH) begin
      st_q <= st_now;
      if (st_now == ST_OK && op_q == OP_RESOLVE) begin
        fk_q <= mem_kind[best_slot_q];
        fo_q <= mem_owner[best_slot_q];
        ro_q <= best_off_q;
      end else begin
        fk_q <= 1'b0;
        fo_q <= '0;
        ro_q <= '0;
      end
    end
  end

  assign status_o           = st_q;
  assign found_kind_o       = fk_q;
  assign found_owner_o      = fo_q;
  assign remainder_offset_o = ro_q;

endmodule

FILE: hw/rtl/pmt_checker.sv
module pmt_checker
  import pmt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic        found_kind_o,
  input logic [63:0] found_owner_o,
  input logic [5:0]  remainder_offset_o
);

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_NOTFOUND))
    else $error("status out of range");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (!found_kind_o && found_owner_o == 64'd0 && remainder_offset_o == 6'd0))
    else $error("fields not cleared");

  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("not busy after taking a word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("stalled word changed");

endmodule

bind path_prefix_mount_table pmt_checker u_pmt_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_stall_o,
  .out_valid_o,
  .out_stall_i,
  .status_o,
  .found_kind_o,
  .found_owner_o,
  .remainder_offset_o
);

FILE: bench/path_prefix_mount_table_tb.sv
`timescale 1ns / 100ps

module path_prefix_mount_table_tb;
  import pmt_pkg::*;

  localparam int unsigned Slots    = 16;
  localparam int unsigned MaxBytes = 31;
  localparam int unsigned NumRand  = 1200;

  typedef struct packed {
    logic [2:0]  status;
    logic        kind;
    logic [63:0] owner;
    logic [5:0]  offset;
  } answer_t;

  typedef struct {
    op_e          op;
    logic [255:0] path;
    logic [15:0]  len;
    logic         kind;
    logic [63:0]  owner;
  } request_t;

  // one directed row: request plus an optional typed-in answer
  typedef struct {
    request_t req;
    bit       has_ans;
    answer_t  ans;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [63:0] path_word0_i = '0, path_word1_i = '0, path_word2_i = '0, path_word3_i = '0;
  logic [15:0] path_length_i = '0;
  logic        entry_kind_i = 1'b0;
  logic [63:0] owner_handle_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic        found_kind_o;
  logic [63:0] found_owner_o;
  logic [5:0]  remainder_offset_o;

  path_prefix_mount_table #(.TABLE_ENTRIES(Slots), .MAX_PATH_BYTES(MaxBytes)) i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the mount table
  bit           mnt_valid [Slots];
  logic [255:0] mnt_path  [Slots];
  logic [4:0]   mnt_len   [Slots];
  logic         mnt_kind  [Slots];
  logic [63:0]  mnt_owner [Slots];

  answer_t pending_answers[$];
  int      errors = 0;
  int      answers_seen = 0;
  int      resolve_hits = 0;
  bit      quiet_tail = 1'b0;  // no idling in the last part of the run

  function automatic logic [7:0] path_byte(logic [255:0] p, int i);
    return p[8*(i%32) +: 8];
  endfunction

  function automatic bit same_head(logic [255:0] a, logic [255:0] b, int n);
    for (int i = 0; i < n && i < 32; i++)
      if (path_byte(a, i) != path_byte(b, i)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int exact_slot(logic [255:0] p, int n);
    for (int s = 0; s < Slots; s++)
      if (mnt_valid[s] && mnt_len[s] == n && same_head(mnt_path[s], p, n)) return s;
    return -1;
  endfunction

  // applies one request to the shadow table and returns the answer
  function automatic answer_t mount_lookup(request_t r);
    answer_t a;
    int n;
    int best;
    int best_off;
    int slot;
    logic [255:0] masked;
    a = '0;
    n = int'(r.len);
    a.status = ST_BAD;
    if (n == 0 || r.op == OP_UNUSED) return a;
    case (r.op)
      OP_RESOLVE: begin
        best = -1;
        best_off = 0;
        for (int s = 0; s < Slots; s++) begin
          int el, off;
          el = int'(mnt_len[s]);
          if (!mnt_valid[s] || n < el || !same_head(mnt_path[s], r.path, el)) continue;
          if (n == el) off = n;
          else if (path_byte(r.path, el) == SepByte) off = el + 1;
          else continue;
          if (best < 0 || el > mnt_len[best]) begin
            best = s;
            best_off = off;
          end
        end
        if (best < 0) a.status = ST_NOTFOUND;
        else begin
          a.status = ST_OK;
          a.kind = mnt_kind[best];
          a.owner = mnt_owner[best];
          a.offset = best_off[5:0];
        end
      end
      OP_INSERT: begin
        if (n > MaxBytes || n > 31 || (r.kind && r.owner == 0)) a.status = ST_BAD;
        else if (exact_slot(r.path, n) >= 0) a.status = ST_DUP;
        else begin
          slot = -1;
          for (int s = 0; s < Slots; s++)
            if (!mnt_valid[s]) begin
              slot = s;
              break;
            end
          if (slot < 0) a.status = ST_FULL;
          else begin
            masked = '0;
            for (int i = 0; i < n; i++) masked[8*i +: 8] = path_byte(r.path, i);
            mnt_path[slot] = masked;
            mnt_len[slot] = n[4:0];
            mnt_kind[slot] = r.kind;
            mnt_owner[slot] = r.owner;
            mnt_valid[slot] = 1'b1;
            a.status = ST_OK;
          end
        end
      end
      default: begin
        slot = (n <= 31) ? exact_slot(r.path, n) : -1;
        if (slot < 0) a.status = ST_NOTFOUND;
        else begin
          mnt_valid[slot] = 1'b0;
          a.status = ST_OK;
        end
      end
    endcase
    return a;
  endfunction

  // word handshake on the request side, driven at the falling edge
  task automatic send_request(request_t r);
    @(negedge clk_i);
    if (!quiet_tail && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    opcode_i <= r.op;
    {path_word3_i, path_word2_i, path_word1_i, path_word0_i} <= r.path;
    path_length_i <= r.len;
    entry_kind_i <= r.kind;
    owner_handle_i <= r.owner;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic queue_and_send(request_t r);
    pending_answers.push_back(mount_lookup(r));
    send_request(r);
  endtask

  // result side: random stall bursts, compare at the rising edge
  initial begin
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $error("unexpected result word, status %0d", status_o);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (want.status == ST_OK && found_owner_o == want.owner && want.offset != 0)
          resolve_hits++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (found_kind_o !== want.kind) begin
          $error("found_kind: expected %0d, got %0d", want.kind, found_kind_o);
          errors++;
        end
        if (found_owner_o !== want.owner) begin
          $error("found_owner: expected %h, got %h", want.owner, found_owner_o);
          errors++;
        end
        if (remainder_offset_o !== want.offset) begin
          $error("remainder_offset: expected %0d, got %0d", want.offset,
                 remainder_offset_o);
          errors++;
        end
      end
    end
  end

  // a small pool of path segments so prefixes actually collide
  function automatic logic [255:0] build_path(output logic [15:0] len);
    logic [255:0] p;
    int n, segs;
    p = '0;
    n = 0;
    segs = $urandom_range(1, 4);
    for (int k = 0; k < segs && n < 31; k++) begin
      int seglen;
      p[8*n +: 8] = SepByte;
      n++;
      seglen = $urandom_range(1, 3);
      for (int j = 0; j < seglen && n < 32; j++) begin
        p[8*n +: 8] = 8'(8'h61 + $urandom_range(0, 2));
        n++;
      end
    end
    len = 16'(n);
    return p;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    r.owner = {$urandom, $urandom};
    r.kind = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    r.path = build_path(r.len);
    if (pick < 40) r.op = OP_RESOLVE;
    else if (pick < 70) r.op = OP_INSERT;
    else if (pick < 88) r.op = OP_REMOVE;
    else begin
      // noise: raw bits, odd lengths, unused opcode, zero handles
      r.op = op_e'($urandom_range(0, 3));
      r.path = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom};
      r.len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 33));
      if ($urandom_range(0, 1)) r.owner = '0;
    end
    // resolve of a path that may extend a mounted one: append a separator tail
    if (r.op == OP_RESOLVE && pick < 20 && r.len < 30) begin
      r.path[8*r.len +: 8] = SepByte;
      r.path[8*(r.len+1) +: 8] = 8'h7A;
      r.len = r.len + 16'd2;
    end
    return r;
  endfunction

  function automatic request_t mk(op_e op, string s, logic kind, logic [63:0] owner);
    request_t r;
    r.op = op;
    r.path = '0;
    for (int i = 0; i < s.len() && i < 32; i++) r.path[8*i +: 8] = s[i];
    r.len = 16'(s.len());
    r.kind = kind;
    r.owner = owner;
    return r;
  endfunction

  row_t    directed[$];
  request_t rq;
  row_t    rw;

  initial begin
    for (int s = 0; s < Slots; s++) begin
      mnt_valid[s] = 1'b0;
      mnt_path[s] = '0;
      mnt_len[s] = '0;
      mnt_kind[s] = 1'b0;
      mnt_owner[s] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table; typed answers only where obvious
    directed.push_back('{mk(OP_RESOLVE, "/a", 0, 0), 1, '{ST_NOTFOUND, 0, 0, 0}});
    directed.push_back('{mk(OP_INSERT, "", 0, 5), 1, '{ST_BAD, 0, 0, 0}});
    directed.push_back('{mk(OP_INSERT, "/k", 1, 0), 1, '{ST_BAD, 0, 0, 0}});
    directed.push_back('{mk(OP_INSERT, "/c", 0, 0), 1, '{ST_OK, 0, 0, 0}});
    directed.push_back('{mk(OP_INSERT, "/c", 1, 9), 1, '{ST_DUP, 0, 0, 0}});
    directed.push_back('{mk(OP_INSERT, "/c/dev", 1, 64'hFFFF_FFFF_FFFF_FFFF), 0, '0});
    directed.push_back('{mk(OP_RESOLVE, "/c/dev/x", 0, 0), 0, '0});
    directed.push_back('{mk(OP_RESOLVE, "/c/devx", 0, 0), 0, '0});
    directed.push_back('{mk(OP_RESOLVE, "/c", 0, 0), 0, '0});
    directed.push_back('{mk(OP_INSERT, "/abcdefghijklmnopqrstuvwxyz01234", 0, 1), 1,
                        '{ST_BAD, 0, 0, 0}});
    directed.push_back('{mk(OP_INSERT, "/abcdefghijklmnopqrstuvwxyz0123", 1, 2), 0, '0});
    directed.push_back('{mk(OP_RESOLVE, "/abcdefghijklmnopqrstuvwxyz0123", 0, 0), 0, '0});
    directed.push_back('{mk(OP_REMOVE, "/zz", 0, 0), 1, '{ST_NOTFOUND, 0, 0, 0}});
    directed.push_back('{mk(OP_REMOVE, "/c", 0, 0), 1, '{ST_OK, 0, 0, 0}});
    directed.push_back('{mk(OP_UNUSED, "/c", 0, 0), 1, '{ST_BAD, 0, 0, 0}});
    directed.push_back('{mk(OP_REMOVE, "", 0, 0), 1, '{ST_BAD, 0, 0, 0}});
    directed.push_back('{mk(OP_RESOLVE, "", 0, 0), 1, '{ST_BAD, 0, 0, 0}});

    foreach (directed[i]) begin
      answer_t predicted;
      rw = directed[i];
      predicted = mount_lookup(rw.req);
      if (rw.has_ans && predicted != rw.ans) begin
        $error("directed row %0d: table answer disagrees with prediction", i);
        errors++;
      end
      pending_answers.push_back(rw.has_ans ? rw.ans : predicted);
      send_request(rw.req);
    end

    // very long length field; remove beyond the hard limit
    rq = mk(OP_REMOVE, "/c/dev", 0, 0);
    rq.len = 16'hFFFF;
    queue_and_send(rq);

    // fill the table to capacity, then hit full and duplicate-while-full
    for (int k = 0; k < Slots + 2; k++) begin
      rq = mk(OP_INSERT, $sformatf("/f%0d", k), 1, 64'(k + 1));
      queue_and_send(rq);
    end
    queue_and_send(mk(OP_INSERT, "/f0", 1, 7));
    for (int k = 0; k < Slots + 2; k++)
      queue_and_send(mk(OP_REMOVE, $sformatf("/f%0d", k), 0, 0));

    for (int k = 0; k < NumRand; k++) begin
      if (k == NumRand - 150) quiet_tail = 1'b1;
      queue_and_send(random_request());
    end

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);

    $display("covered %0d result words, %0d successful resolves, full/dup/bad paths",
             answers_seen, resolve_hits);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // watchdog: bounds a run of ~1260 words with their stalls and gaps, with ample margin
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: path_prefix_mount_table.f
hw/rtl/pmt_pkg.sv
hw/rtl/pmt_byte_cmp.sv
hw/rtl/path_prefix_mount_table.sv
hw/rtl/pmt_checker.sv
bench/path_prefix_mount_table_tb.sv
